FILE: src/receipt_keyed_item_store_unit_macros.svh
// Assertion macros for the receipt store.
// Both macros expect clk and rst_n in scope.
`ifndef RECEIPT_KEYED_ITEM_STORE_UNIT_MACROS_SVH
`define RECEIPT_KEYED_ITEM_STORE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define RKIS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rkis assertion failed");
`define RKIS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rkis assertion failed");
`else
`define RKIS_ASSERT(label, prop)
`define RKIS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: src/rkis_pkg.sv
package rkis_pkg;

    localparam int OP_W     = 1;
    localparam int ITEM_W   = 32;
    localparam int RCPT_W   = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
    localparam logic [OP_W-1:0] OP_POP    = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EXHAUSTED = 2'd3
    } status_t;

endpackage

FILE: src/receipt_keyed_item_store_unit.sv
// Receipt bag: an insert stores item_value in a free slot and returns the next receipt
// (1, 2, 3, ...); a pop redeems a receipt, returns its value and frees the slot. Every
// request yields exactly one result beat carrying status and the entry count after the
// request. Slots live in a single memory with one write and one registered read port and
// are scanned one entry per cycle, ending early on the first matching slot; a refused insert
// (bag full, receipts exhausted) skips the scan and raises its result without reading memory.
// One request is in flight at a time; a new one is taken while the previous result still
// waits on the output. After reset a clearing pass invalidates every slot before the first
// request is accepted.
`include "receipt_keyed_item_store_unit_macros.svh"

module receipt_keyed_item_store_unit
    import rkis_pkg::*;
#(
    parameter int CAPACITY      = 16,
    parameter int VALUE_WIDTH   = 32,
    parameter int RECEIPT_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     operation,
    input  logic [ITEM_W-1:0]   item_value,
    input  logic [RCPT_W-1:0]   receipt,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [RCPT_W-1:0]   issued_receipt,
    output logic [ITEM_W-1:0]   returned_value,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  entry_count
);

    localparam int AW     = $clog2(CAPACITY);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int RW     = RECEIPT_WIDTH;
    localparam int VW     = VALUE_WIDTH;
    localparam int WORD_W = 1 + RW + VW;

    typedef struct packed {
        logic          valid;
        logic [RW-1:0] rcpt;
        logic [VW-1:0] value;
    } slot_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      cnt_reg;
    logic               pend_reg;
    logic [AW-1:0]      chk_addr_reg;
    logic [OP_W-1:0]    op_reg;
    logic [VW-1:0]      value_reg;
    logic [RW-1:0]      want_reg;
    logic               hit_reg;
    logic [AW-1:0]      hit_addr_reg;
    logic [VW-1:0]      res_value_reg;
    status_t            res_status_reg;
    logic [RW-1:0]      next_receipt_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;

    logic               out_valid_reg;
    logic [RCPT_W-1:0]  issued_receipt_reg;
    logic [ITEM_W-1:0]  returned_value_reg;
    status_t            out_status_reg;
    logic [COUNT_W-1:0] entry_count_reg;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    slot_t              wr_slot;
    logic               rd_en;
    logic [WORD_W-1:0]  rd_data;
    slot_t              rd_slot;

    logic               bag_full;
    logic               scan_hit;
    logic               scan_last;
    logic               commit;

    rkis_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  (WORD_W),
        .ADDR_W (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_slot),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign rd_slot   = rd_data;
    assign bag_full  = (count_reg == CW'(CAPACITY));
    assign rd_en     = (state_reg == S_SCAN) && (cnt_reg < CW'(CAPACITY));
    assign scan_hit  = pend_reg &&
                       ((op_reg == OP_INSERT) ? !rd_slot.valid
                                              : (rd_slot.valid && (rd_slot.rcpt == want_reg)));
    assign scan_last = pend_reg && (chk_addr_reg == AW'(CAPACITY - 1));
    assign commit    = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg[AW-1:0];
        wr_slot = '0;
        priority if (state_reg == S_CLEAR)
        begin
            wr_en = 1'b1;
        end
        else if (commit && hit_reg)
        begin
            wr_en         = 1'b1;
            wr_addr       = hit_addr_reg;
            wr_slot.valid = (op_reg == OP_INSERT);
            wr_slot.rcpt  = next_receipt_reg;
            wr_slot.value = value_reg;
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (commit && hit_reg)
        begin
            if (op_reg == OP_INSERT)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (count_reg != '0)
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            cnt_reg          <= '0;
            pend_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            next_receipt_reg <= RW'(1);
            count_reg        <= '0;
        end
        else
        begin
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (cnt_reg == CW'(CAPACITY - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= operation;
                        value_reg <= VW'(item_value);
                        want_reg  <= RW'(receipt);
                        cnt_reg   <= '0;
                        pend_reg  <= 1'b0;
                        hit_reg   <= 1'b0;
                        priority if (operation == OP_INSERT && bag_full)
                        begin
                            res_status_reg <= ST_FULL;
                            state_reg      <= S_DONE;
                        end
                        else if (operation == OP_INSERT && next_receipt_reg == '0)
                        begin
                            res_status_reg <= ST_EXHAUSTED;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    pend_reg     <= rd_en;
                    chk_addr_reg <= cnt_reg[AW-1:0];
                    if (rd_en)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    priority if (scan_hit)
                    begin
                        hit_reg        <= 1'b1;
                        hit_addr_reg   <= chk_addr_reg;
                        res_value_reg  <= rd_slot.value;
                        res_status_reg <= ST_OK;
                        state_reg      <= S_DONE;
                    end
                    else if (scan_last)
                    begin
                        res_status_reg <= (op_reg == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_DONE:
                begin
                    if (commit)
                    begin
                        out_status_reg     <= res_status_reg;
                        entry_count_reg    <= COUNT_W'(count_next);
                        count_reg          <= count_next;
                        issued_receipt_reg <= (hit_reg && op_reg == OP_INSERT) ?
                                              RCPT_W'(next_receipt_reg) : '0;
                        returned_value_reg <= (hit_reg && op_reg == OP_POP) ?
                                              ITEM_W'(res_value_reg) : '0;
                        if (hit_reg && op_reg == OP_INSERT)
                        begin
                            next_receipt_reg <= next_receipt_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign issued_receipt = issued_receipt_reg;
    assign returned_value = returned_value_reg;
    assign status         = out_status_reg;
    assign entry_count    = entry_count_reg;

    `RKIS_ASSERT(a_refused_zero, out_valid_reg && out_status_reg != ST_OK |-> issued_receipt_reg == '0 && returned_value_reg == '0)
    `RKIS_ASSERT(a_write_source, wr_en |-> state_reg == S_CLEAR || commit)
    `RKIS_ASSERT(a_issue_nonzero, commit && hit_reg && op_reg == OP_INSERT |-> next_receipt_reg != '0)
    `RKIS_ASSERT_NEXT(a_insert_count, commit && hit_reg && op_reg == OP_INSERT, count_reg == $past(count_reg) + 1'b1)
    `RKIS_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_reg == S_SCAN || state_reg == S_DONE)

endmodule

FILE: src/rkis_ram.sv
module rkis_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 49,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import rkis_pkg::*;

    localparam int BAG_SLOTS    = 16;
    localparam int CYCLE_LIMIT  = 8_000_000;
    localparam int RANDOM_ITEMS = 660;
    localparam int SHOW_LIMIT   = 10;

    typedef struct {
        logic [RCPT_W-1:0]  rcpt;
        logic [ITEM_W-1:0]  value;
        status_t            st;
        logic [COUNT_W-1:0] count;
    } bag_reply_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

    class bag_ledger;
        bit                used [BAG_SLOTS];
        logic [RCPT_W-1:0] slot_rcpt [BAG_SLOTS];
        logic [ITEM_W-1:0] slot_val [BAG_SLOTS];
        logic [RCPT_W-1:0] next_rcpt;
        int unsigned       held;
        bag_reply_t        awaited [$];
        int                failures;
        int                replies;
        int                inserts;
        int                pops;
        int                status_seen [4];

        function new();
            foreach (used[i])
                used[i] = 1'b0;
            foreach (status_seen[i])
                status_seen[i] = 0;
            next_rcpt = 1;
            held      = 0;
            failures  = 0;
            replies   = 0;
            inserts   = 0;
            pops      = 0;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [ITEM_W-1:0] val,
                                   logic [RCPT_W-1:0] rc);
            bag_reply_t r;
            int         slot;
            r.rcpt  = '0;
            r.value = '0;
            r.st    = ST_OK;
            slot    = -1;
            if (op == OP_INSERT)
            begin
                inserts++;
                if (held >= BAG_SLOTS)
                begin
                    r.st = ST_FULL;
                end
                else if (next_rcpt == '0)
                begin
                    r.st = ST_EXHAUSTED;
                end
                else
                begin
                    for (int i = 0; i < BAG_SLOTS; i++)
                    begin
                        if (!used[i])
                        begin
                            slot = i;
                            break;
                        end
                    end
                    if (slot < 0)
                    begin
                        r.st = ST_FULL;
                    end
                    else
                    begin
                        used[slot]      = 1'b1;
                        slot_rcpt[slot] = next_rcpt;
                        slot_val[slot]  = val;
                        r.rcpt          = next_rcpt;
                        next_rcpt       = next_rcpt + 1'b1;
                        held++;
                    end
                end
            end
            else
            begin
                pops++;
                r.st = ST_NOT_FOUND;
                for (int i = 0; i < BAG_SLOTS; i++)
                begin
                    if (used[i] && slot_rcpt[i] == rc)
                    begin
                        r.value = slot_val[i];
                        used[i] = 1'b0;
                        if (held > 0)
                            held--;
                        r.st = ST_OK;
                        break;
                    end
                end
            end
            r.count = COUNT_W'(held);
            status_seen[int'(r.st)]++;
            awaited = {awaited, r};
        endfunction

        function void check_reply(logic [RCPT_W-1:0] ir, logic [ITEM_W-1:0] rv,
                                  logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] cnt);
            bag_reply_t e;
            replies++;
            if (awaited.size() == 0)
            begin
                failures++;
                if (failures <= SHOW_LIMIT)
                    $display("result beat %0d arrived with nothing expected", replies);
                return;
            end
            e = awaited.pop_front();
            if (ir !== e.rcpt || rv !== e.value || st !== e.st || cnt !== e.count)
            begin
                failures++;
                if (failures <= SHOW_LIMIT)
                    $display({"result beat %0d mismatch (expected/actual): receipt %h/%h ",
                              "value %h/%h status %0d/%0d count %0d/%0d"},
                             replies, e.rcpt, ir, e.value, rv, e.st, st, e.count, cnt);
            end
        endfunction

        function logic [RCPT_W-1:0] pick_held();
            int idx [$];
            for (int i = 0; i < BAG_SLOTS; i++)
                if (used[i])
                    idx = {idx, i};
            if (idx.size() == 0)
                return '0;
            return slot_rcpt[idx[$urandom_range(0, idx.size() - 1)]];
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [OP_W-1:0]     operation = OP_INSERT;
    logic [ITEM_W-1:0]   item_value = '0;
    logic [RCPT_W-1:0]   receipt = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [RCPT_W-1:0]   issued_receipt;
    logic [ITEM_W-1:0]   returned_value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;

    bag_ledger         ledger = new();
    int                cycles = 0;
    int                burst_left = 0;
    int                hold_req = 0;
    int                hold_left = 0;
    int                mode_left = 0;
    int                pattern_ctr = 0;
    bit                rx_fast = 1'b0;
    rx_mode_t          rx_mode = RX_OPEN;
    logic [RCPT_W-1:0] last_redeemed = '0;

    receipt_keyed_item_store_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .item_value     (item_value),
        .receipt        (receipt),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .issued_receipt (issued_receipt),
        .returned_value (returned_value),
        .status         (status),
        .entry_count    (entry_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("receipt_keyed_item_store_unit verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            ledger.check_reply(issued_receipt, returned_value, status, entry_count);
    end

    // Receiver: hold-off requests win, then fast mode, then the current stall pattern.
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (rx_fast)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            pattern_ctr++;
            case (rx_mode)
                RX_OPEN:    out_ready <= 1'b1;
                RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
                RX_PATTERN: out_ready <= (pattern_ctr % 7) >= 3;
                default:    out_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    task automatic send_request(logic [OP_W-1:0] op, logic [ITEM_W-1:0] val,
                                logic [RCPT_W-1:0] rc);
        operation  <= op;
        item_value <= val;
        receipt    <= rc;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        ledger.note_request(op, val, rc);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ledger.awaited.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random(int insert_pct, bit paced);
        logic [ITEM_W-1:0] val;
        logic [RCPT_W-1:0] rc;
        int                k;
        val = $urandom;
        rc  = 16'($urandom);
        k   = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < insert_pct)
        begin
            if (k < 10)
                val = '0;
            else if (k < 20)
                val = '1;
            send_request(OP_INSERT, val, rc);
        end
        else
        begin
            if (k < 75)
            begin
                rc = ledger.pick_held();
                last_redeemed = rc;
            end
            else if (k < 83)
            begin
                rc = last_redeemed;
            end
            else if (k < 88)
            begin
                rc = '0;
            end
            else if (k < 93)
            begin
                rc = ledger.next_rcpt;
            end
            send_request(OP_POP, val, rc);
        end
        if (paced)
            pace_sender();
    endtask

    task automatic empty_bag();
        while (ledger.held != 0)
        begin
            send_request(OP_POP, $urandom, ledger.pick_held());
            if (!rx_fast)
                pace_sender();
        end
    endtask

    initial
    begin
        int insert_pct;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_POP, 32'hDEAD_BEEF, 16'h0000);
        send_request(OP_POP, '0, 16'hFFFF);
        send_request(OP_INSERT, 32'h0000_0000, 16'hFFFF);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 16'h0000);
        pace_sender();
        send_request(OP_INSERT, 32'h8000_0001, 16'h0001);
        send_request(OP_POP, 32'hFFFF_FFFF, 16'd1);
        send_request(OP_POP, '0, 16'd1);
        send_request(OP_POP, '0, 16'd2);
        for (int i = 0; i < 15; i++)
        begin
            send_request(OP_INSERT, 32'h1111_0000 + i, 16'(i));
            pace_sender();
        end
        send_request(OP_INSERT, 32'hCAFE_F00D, 16'h1234);
        send_request(OP_POP, 32'h5555_AAAA, 16'd10);
        send_request(OP_INSERT, 32'h0BAD_0BAD, 16'hAAAA);

        insert_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 60 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 75;
                    1:       insert_pct = 30;
                    default: insert_pct = 50;
                endcase
            end
            if (n == 250 || n == 500)
            begin
                // Hold the output long enough that the block backs up on its input.
                hold_req = 80;
                for (int j = 0; j < 10; j++)
                    send_random(insert_pct, 1'b0);
                n += 10;
            end
            if (n == 375)
                wait_quiet();
            send_random(insert_pct, 1'b1);
        end

        // Fill the bag from empty, then probe refusals while full.
        wait_quiet();
        empty_bag();
        wait_quiet();
        rx_fast = 1'b1;
        for (int i = 0; i < BAG_SLOTS; i++)
            send_request(OP_INSERT, $urandom, 16'($urandom));
        send_request(OP_INSERT, 32'h1357_9BDF, '0);
        send_request(OP_POP, '0, 16'hFFFF);
        send_request(OP_INSERT, 32'h2468_ACE0, '0);
        rx_fast = 1'b0;
        for (int n = 0; n < 30; n++)
            send_random(40, 1'b1);
        empty_bag();
        send_request(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(OP_POP, '0, 16'h0000);

        wait_quiet();
        repeat (BAG_SLOTS + 8) @(posedge clk);
        $display("requests: %0d inserts, %0d pops, %0d result beats checked",
                 ledger.inserts, ledger.pops, ledger.replies);
        $display("status mix: ok %0d, not found %0d, full %0d, exhausted %0d; mismatches %0d",
                 ledger.status_seen[ST_OK], ledger.status_seen[ST_NOT_FOUND],
                 ledger.status_seen[ST_FULL], ledger.status_seen[ST_EXHAUSTED],
                 ledger.failures);
        if (ledger.failures == 0 && ledger.awaited.size() == 0)
            $display("receipt_keyed_item_store_unit verification clean");
        else
            $display("receipt_keyed_item_store_unit verification failed");
        $finish;
    end

endmodule
